// ----- hdl/cgt_pkg.sv -----
// constants and types shared by the circle geofence tracker
// no dependencies
package cgt_pkg;
	localparam logic [1:0] MODE_FENCE = 2'd0;
	localparam logic [1:0] MODE_POS   = 2'd1;
	localparam logic [1:0] MODE_END   = 2'd2;
	localparam logic [1:0] MODE_QUERY = 2'd3;

	localparam logic [1:0] KIND_ENTER = 2'd0;
	localparam logic [1:0] KIND_EXIT  = 2'd1;
	localparam logic [1:0] KIND_QUERY = 2'd2;
endpackage

// ----- hdl/circle_geofence_tracker.sv -----
// circle geofence tracker: accepts a request when start is high and busy is low, and
// produces results one cycle long, marked by strobe, which the receiver cannot stall.
// Fence writes and positions are taken in the idle state; a query holds busy through
// ST_QUERY, which registers its strobed answer. At frame end the block clears absent rows
// (and all rows of disabled fences) in ST_CLEAR, then walks every fence and buffered
// position pair through one shared squared-distance unit in the steps operands, dx*dx,
// dz*dz, r*r and compare, since one 25x25 multiplier computes the squares in turn, and
// passes through ST_NEXT after each fence. A disabled fence or an empty buffer goes
// straight from ST_PAIR to ST_NEXT. Busy stays high for the walk. At most one event is
// emitted per pair.
// depends on cgt_pkg
module circle_geofence_tracker #(
	parameter int FENCE_COUNT = 8,
	parameter int CHAR_COUNT  = 8,
	parameter int FRAME_DEPTH = 8,
	parameter int COORD_BITS  = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  mode,
	input  logic [2:0]  fence_slot,
	input  logic signed [23:0] fence_x,
	input  logic signed [23:0] fence_z,
	input  logic [22:0] fence_radius,
	input  logic        fence_on,
	input  logic [2:0]  char_slot,
	input  logic signed [23:0] char_x,
	input  logic signed [23:0] char_z,
	input  logic        last_in_frame,
	output logic        strobe,
	output logic [1:0]  out_kind,
	output logic [2:0]  out_fence,
	output logic [2:0]  out_char,
	output logic        out_inside,
	output logic        out_last
);
	localparam int FW = (FENCE_COUNT > 1) ? $clog2(FENCE_COUNT) : 1;
	localparam int CW = (CHAR_COUNT > 1) ? $clog2(CHAR_COUNT) : 1;
	localparam int PW = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
	localparam int NW = $clog2(FRAME_DEPTH + 1);
	localparam int DW = COORD_BITS + 1;
	localparam int SW = 2 * DW + 1;

	typedef enum logic [3:0] {
		ST_IDLE, ST_QUERY, ST_CLEAR, ST_PAIR, ST_MX, ST_MZ, ST_MR, ST_DECIDE, ST_NEXT
	} state_t;

	state_t state_q;
	logic signed [COORD_BITS-1:0] fx_q [FENCE_COUNT];
	logic signed [COORD_BITS-1:0] fz_q [FENCE_COUNT];
	logic [COORD_BITS-2:0] fr_q [FENCE_COUNT];
	logic [FENCE_COUNT-1:0] fvalid_q;
	logic [CHAR_COUNT-1:0] rows_q [FENCE_COUNT];
	logic [CW-1:0] pc_q [FRAME_DEPTH];
	logic signed [COORD_BITS-1:0] px_q [FRAME_DEPTH];
	logic signed [COORD_BITS-1:0] pz_q [FRAME_DEPTH];
	logic [NW-1:0] count_q;
	logic [CHAR_COUNT-1:0] present_q;
	logic [FW-1:0] f_q;
	logic [PW-1:0] p_q;
	logic [DW-1:0] dx_q, dz_q, ma_q;
	logic [SW-1:0] acc_q;
	logic [2*DW-1:0] prod_q;
	logic pend_q;
	logic [1:0] pkind_q;
	logic [2:0] pfence_q, pchar_q;
	logic [2:0] qf_q, qc_q;
	logic qa_q;

	logic [2*DW-1:0] prod;
	logic signed [DW-1:0] ax, bx, az, bz;
	logic signed [DW-1:0] sx, sz;
	logic now_in, was_in;
	logic [CW-1:0] cur_c;
	logic last_pair;
	logic fs_ok, cs_ok;

	// shared multiplier, operand picked by the sequencer
	assign prod = ma_q * ma_q;
	assign ax = DW'(fx_q[f_q]);
	assign bx = DW'(px_q[p_q]);
	assign az = DW'(fz_q[f_q]);
	assign bz = DW'(pz_q[p_q]);
	assign sx = bx - ax;
	assign sz = bz - az;
	assign cur_c = pc_q[p_q];
	assign was_in = rows_q[f_q][cur_c];
	// acc holds dx2+dz2; compare with r2
	assign now_in = acc_q < SW'(prod_q);
	assign last_pair = (32'(p_q) + 1 >= 32'(count_q));
	assign fs_ok = 32'(fence_slot) < FENCE_COUNT;
	assign cs_ok = 32'(char_slot) < CHAR_COUNT;
	assign busy = (state_q != ST_IDLE);

	// the last event is known only once the walk finishes, so one event is held back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fvalid_q <= '0;
			for (int i = 0; i < FENCE_COUNT; i++) rows_q[i] <= '0;
			count_q <= '0;
			present_q <= '0;
			f_q <= '0;
			p_q <= '0;
			pend_q <= 1'b0;
			strobe <= 1'b0;
			out_kind <= '0; out_fence <= '0; out_char <= '0;
			out_inside <= 1'b0; out_last <= 1'b0;
		end else begin
			strobe <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						unique case (mode)
							cgt_pkg::MODE_FENCE: begin
								if (fs_ok) begin
									if (fence_on) begin
										fx_q[FW'(fence_slot)] <= COORD_BITS'(fence_x);
										fz_q[FW'(fence_slot)] <= COORD_BITS'(fence_z);
										fr_q[FW'(fence_slot)] <= (COORD_BITS-1)'(fence_radius);
										fvalid_q[FW'(fence_slot)] <= 1'b1;
									end else begin
										fvalid_q[FW'(fence_slot)] <= 1'b0;
										rows_q[FW'(fence_slot)] <= '0;
									end
								end
							end
							cgt_pkg::MODE_POS: begin
								if (cs_ok && 32'(count_q) < FRAME_DEPTH) begin
									pc_q[PW'(count_q)] <= CW'(char_slot);
									px_q[PW'(count_q)] <= COORD_BITS'(char_x);
									pz_q[PW'(count_q)] <= COORD_BITS'(char_z);
									count_q <= count_q + 1'b1;
									present_q[CW'(char_slot)] <= 1'b1;
								end
								if (last_in_frame) state_q <= ST_CLEAR;
							end
							cgt_pkg::MODE_END: state_q <= ST_CLEAR;
							cgt_pkg::MODE_QUERY: begin
								qf_q <= fence_slot;
								qc_q <= char_slot;
								qa_q <= fs_ok && cs_ok && fvalid_q[FW'(fence_slot)]
									&& rows_q[FW'(fence_slot)][CW'(char_slot)];
								state_q <= ST_QUERY;
							end
							default: ;
						endcase
					end
				end
				ST_QUERY: begin
					strobe <= 1'b1;
					out_kind <= cgt_pkg::KIND_QUERY;
					out_fence <= qf_q; out_char <= qc_q;
					out_inside <= qa_q; out_last <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_CLEAR: begin
					for (int i = 0; i < FENCE_COUNT; i++)
						rows_q[i] <= fvalid_q[i] ? (rows_q[i] & present_q) : '0;
					f_q <= '0; p_q <= '0;
					state_q <= ST_PAIR;
				end
				ST_PAIR: begin
					if (!fvalid_q[f_q] || count_q == '0) begin
						state_q <= ST_NEXT;
					end else begin
						dx_q <= sx[DW-1] ? DW'(-sx) : DW'(sx);
						dz_q <= sz[DW-1] ? DW'(-sz) : DW'(sz);
						ma_q <= sx[DW-1] ? DW'(-sx) : DW'(sx);
						state_q <= ST_MX;
					end
				end
				ST_MX: begin
					acc_q <= SW'(prod);
					ma_q <= dz_q;
					state_q <= ST_MZ;
				end
				ST_MZ: begin
					acc_q <= acc_q + SW'(prod);
					ma_q <= DW'(fr_q[f_q]);
					state_q <= ST_MR;
				end
				ST_MR: begin
					prod_q <= prod;
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (now_in != was_in) begin
						rows_q[f_q][cur_c] <= now_in;
						if (pend_q) begin
							strobe <= 1'b1;
							out_kind <= pkind_q; out_fence <= pfence_q;
							out_char <= pchar_q; out_inside <= 1'b0; out_last <= 1'b0;
						end
						pend_q <= 1'b1;
						pkind_q <= now_in ? cgt_pkg::KIND_ENTER : cgt_pkg::KIND_EXIT;
						pfence_q <= 3'(f_q);
						pchar_q <= 3'(cur_c);
					end
					if (last_pair) state_q <= ST_NEXT;
					else begin
						p_q <= p_q + 1'b1;
						state_q <= ST_PAIR;
					end
				end
				ST_NEXT: begin
					p_q <= '0;
					if (32'(f_q) + 1 >= FENCE_COUNT) begin
						if (pend_q) begin
							strobe <= 1'b1;
							out_kind <= pkind_q; out_fence <= pfence_q;
							out_char <= pchar_q; out_inside <= 1'b0; out_last <= 1'b1;
						end
						pend_q <= 1'b0;
						count_q <= '0;
						present_q <= '0;
						state_q <= ST_IDLE;
					end else begin
						f_q <= f_q + 1'b1;
						state_q <= ST_PAIR;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ----- sim/tb_top.sv -----
// testbench for the circle geofence tracker: random and directed requests,
// predicted events and query answers checked field by field
// depends on cgt_pkg and circle_geofence_tracker
`timescale 1ns / 100ps
module tb_top;
	typedef struct packed {
		logic [1:0] kind;
		logic [2:0] fence;
		logic [2:0] chr;
		logic       hit;
		logic       last;
	} geo_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] mode = '0;
	logic [2:0] fence_slot = '0;
	logic signed [23:0] fence_x = '0;
	logic signed [23:0] fence_z = '0;
	logic [22:0] fence_radius = '0;
	logic fence_on = 1'b0;
	logic [2:0] char_slot = '0;
	logic signed [23:0] char_x = '0;
	logic signed [23:0] char_z = '0;
	logic last_in_frame = 1'b0;
	logic strobe;
	logic [1:0] out_kind;
	logic [2:0] out_fence;
	logic [2:0] out_char;
	logic out_inside;
	logic out_last;

	circle_geofence_tracker dut (.*);

	always #5 clk = ~clk;

	// predictor state
	logic signed [24:0] fx [8];
	logic signed [24:0] fz [8];
	logic [22:0] frad [8];
	logic fvalid [8];
	logic [7:0] rows [8];
	logic [2:0] buf_char [8];
	logic signed [24:0] buf_x [8];
	logic signed [24:0] buf_z [8];
	int buf_count;
	logic [7:0] present;

	geo_result_t expected_results[$];
	int errors = 0;
	int n_requests = 0;
	int n_results = 0;
	int cycles = 0;
	bit allow_idle = 1'b1;

	function automatic bit in_circle(logic signed [24:0] px, logic signed [24:0] pz,
			logic signed [24:0] cx, logic signed [24:0] cz, logic [22:0] r);
		longint dx, dz, rr;
		dx = longint'(px) - longint'(cx);
		dz = longint'(pz) - longint'(cz);
		rr = longint'(r);
		return (dx * dx + dz * dz) < rr * rr;
	endfunction

	task automatic enqueue_expected(geo_result_t r);
		expected_results = {expected_results, r};
	endtask

	task automatic close_frame();
		geo_result_t ev;
		bit now;
		int first;
		first = expected_results.size();
		for (int f = 0; f < 8; f++) begin
			if (!fvalid[f]) continue;
			rows[f] &= present;
			for (int p = 0; p < buf_count; p++) begin
				now = in_circle(buf_x[p], buf_z[p], fx[f], fz[f], frad[f]);
				if (now == rows[f][buf_char[p]]) continue;
				rows[f][buf_char[p]] = now;
				ev.kind = now ? cgt_pkg::KIND_ENTER : cgt_pkg::KIND_EXIT;
				ev.fence = f[2:0];
				ev.chr = buf_char[p];
				ev.hit = 1'b0;
				ev.last = 1'b0;
				enqueue_expected(ev);
			end
		end
		if (expected_results.size() > first)
			expected_results[expected_results.size() - 1].last = 1'b1;
		buf_count = 0;
		present = '0;
	endtask

	task automatic predict_request();
		geo_result_t q;
		unique case (mode)
			cgt_pkg::MODE_FENCE: begin
				if (fence_on) begin
					fx[fence_slot] = 25'(fence_x);
					fz[fence_slot] = 25'(fence_z);
					frad[fence_slot] = fence_radius;
					fvalid[fence_slot] = 1'b1;
				end else begin
					fvalid[fence_slot] = 1'b0;
					rows[fence_slot] = '0;
				end
			end
			cgt_pkg::MODE_POS: begin
				if (buf_count < 8) begin
					buf_char[buf_count] = char_slot;
					buf_x[buf_count] = 25'(char_x);
					buf_z[buf_count] = 25'(char_z);
					buf_count++;
					present[char_slot] = 1'b1;
				end
				if (last_in_frame) close_frame();
			end
			cgt_pkg::MODE_END: close_frame();
			cgt_pkg::MODE_QUERY: begin
				q.kind = cgt_pkg::KIND_QUERY;
				q.fence = fence_slot;
				q.chr = char_slot;
				q.hit = fvalid[fence_slot] ? rows[fence_slot][char_slot] : 1'b0;
				q.last = 1'b1;
				enqueue_expected(q);
			end
		endcase
	endtask

	// one request: drive at an edge, hold until accepted
	task automatic send(logic [1:0] m, logic [2:0] fs, logic [23:0] x0, logic [23:0] z0,
			logic [22:0] r, logic on, logic [2:0] cs, logic [23:0] x1, logic [23:0] z1,
			logic lst);
		int gap;
		if (allow_idle && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 3);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		mode <= m;
		fence_slot <= fs;
		fence_x <= x0;
		fence_z <= z0;
		fence_radius <= r;
		fence_on <= on;
		char_slot <= cs;
		char_x <= x1;
		char_z <= z1;
		last_in_frame <= lst;
		do @(posedge clk); while (busy);
		predict_request();
		n_requests++;
	endtask

	task automatic put_fence(int s, int x, int z, int r, bit on);
		send(cgt_pkg::MODE_FENCE, 3'(s), 24'(x), 24'(z), 23'(r), on, 3'($urandom),
			24'($urandom), 24'($urandom), 1'($urandom));
	endtask

	task automatic put_pos(int c, int x, int z, bit lst);
		send(cgt_pkg::MODE_POS, 3'($urandom), 24'($urandom), 24'($urandom), 23'($urandom),
			1'($urandom), 3'(c), 24'(x), 24'(z), lst);
	endtask

	task automatic ask(int f, int c);
		send(cgt_pkg::MODE_QUERY, 3'(f), 24'($urandom), 24'($urandom), 23'($urandom),
			1'($urandom), 3'(c), 24'($urandom), 24'($urandom), 1'($urandom));
	endtask

	task automatic end_frame_cmd();
		send(cgt_pkg::MODE_END, 3'($urandom), 24'($urandom), 24'($urandom), 23'($urandom),
			1'($urandom), 3'($urandom), 24'($urandom), 24'($urandom), 1'($urandom));
	endtask

	task automatic drain();
		start <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic test_directed();
		put_fence(0, 0, 0, 100, 1'b1);
		put_fence(1, -8388608, -8388608, 8388607, 1'b1);
		put_fence(2, 8388607, 8388607, 0, 1'b1);
		put_fence(3, 8388607, -8388608, 8388607, 1'b1);
		put_pos(0, 0, 0, 1'b0);
		put_pos(1, 100, 0, 1'b0);                // on the edge: outside
		put_pos(2, 8388607, 8388607, 1'b0);
		put_pos(3, -8388608, -8388608, 1'b1);
		ask(0, 0);
		ask(1, 3);
		ask(5, 5);
		// same character twice: enter then exit
		put_pos(4, 10, 10, 1'b0);
		put_pos(4, 1000, 1000, 1'b1);
		// characters missing from this frame lose their bits silently
		put_pos(0, 5, 5, 1'b1);
		ask(0, 0);
		end_frame_cmd();
		// buffer overflow: ninth position dropped but still closes the frame
		for (int i = 0; i < 8; i++) put_pos(i, i, 0, 1'b0);
		put_pos(7, 9999, 9999, 1'b1);
		put_fence(0, 0, 0, 0, 1'b0);
		ask(0, 1);
		end_frame_cmd();
		drain();
	endtask

	task automatic test_random(int count, bit idle);
		int kind, sz;
		allow_idle = idle;
		for (int i = 0; i < count; i++) begin
			kind = $urandom_range(0, 9);
			if (kind == 0) begin
				sz = ($urandom_range(0, 3) == 0) ? 8388607 : int'($urandom_range(0, 4000));
				put_fence($urandom_range(0, 7), $signed($urandom_range(0, 4000)) - 2000,
					$signed($urandom_range(0, 4000)) - 2000, sz, $urandom_range(0, 5) != 0);
			end else if (kind == 1) begin
				put_fence($urandom_range(0, 7), $urandom, $urandom, $urandom,
					1'($urandom_range(0, 1)));
			end else if (kind <= 6) begin
				if ($urandom_range(0, 7) == 0)
					put_pos($urandom_range(0, 7), $urandom, $urandom,
						$urandom_range(0, 3) == 0);
				else
					put_pos($urandom_range(0, 7), $signed($urandom_range(0, 6000)) - 3000,
						$signed($urandom_range(0, 6000)) - 3000, $urandom_range(0, 3) == 0);
			end else if (kind == 7) begin
				end_frame_cmd();
			end else begin
				ask($urandom_range(0, 7), $urandom_range(0, 7));
			end
			if (i == count / 2) drain();
		end
		drain();
	endtask

	// result checker: the receiver never stalls
	always @(posedge clk) begin
		geo_result_t want;
		if (arst_n && strobe) begin
			n_results++;
			if (expected_results.size() == 0) begin
				$error("unexpected result kind=%0d fence=%0d char=%0d", out_kind,
					out_fence, out_char);
				errors++;
			end else begin
				want = expected_results.pop_front();
				if (out_kind !== want.kind) begin
					$error("out_kind expected %0d got %0d", want.kind, out_kind);
					errors++;
				end
				if (out_fence !== want.fence) begin
					$error("out_fence expected %0d got %0d", want.fence, out_fence);
					errors++;
				end
				if (out_char !== want.chr) begin
					$error("out_char expected %0d got %0d", want.chr, out_char);
					errors++;
				end
				if (out_inside !== want.hit) begin
					$error("out_inside expected %0d got %0d", want.hit, out_inside);
					errors++;
				end
				if (out_last !== want.last) begin
					$error("out_last expected %0d got %0d", want.last, out_last);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 500000) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < 8; i++) begin
			fvalid[i] = 1'b0;
			rows[i] = '0;
		end
		buf_count = 0;
		present = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(170, 1'b1);
		test_random(60, 1'b0);
		if (expected_results.size() != 0) errors++;
		$display("covered %0d requests and %0d results: fence writes, positions,", n_requests,
			n_results);
		$display("frame ends, overflow and queries");
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule

// ----- circle_geofence_tracker.f -----
hdl/cgt_pkg.sv
hdl/circle_geofence_tracker.sv
sim/tb_top.sv
